// ----- rtl/euc_cn_mule_transcoder_defines.svh -----
// Assertion macros used by the transcoder top level.
`ifndef EUC_CN_MULE_TRANSCODER_DEFINES_SVH
`define EUC_CN_MULE_TRANSCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ECMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transcoder assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ECMT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transcoder assertion failed");

`endif

// ----- rtl/ecmt_pkg.sv -----
// Types, constants and register codes of the EUC-CN / MULE transcoder.
package ecmt_pkg;

  localparam int COUNT_WIDTH_DEF = 31;
  localparam int CONSUMED_W      = 31;
  localparam int MAX_RESULTS     = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NO_ERROR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GB_LEADER = 2'd2;

  localparam logic [7:0] GB_LEADER_RST = 8'd129;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_UNTRANS = 2'd2;

  localparam logic DIR_TO_MULE = 1'b0;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_ONE   = 3'b010,
    PH_TWO   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  is_terminator;
    logic [1:0]            status;
    logic [CONSUMED_W-1:0] consumed;
    logic                  last_of_run;
  } out_item_t;

  typedef struct packed {
    logic       direction;
    logic       no_error;
    logic [7:0] gb_leader;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] held_first;
    logic [7:0] held_second;
    logic       stopped;
    logic [1:0] stop_cause;
  } conv_state_t;

endpackage

// ----- rtl/ecmt_step.sv -----
// Conversion of one item: next state, next count and up to four results.
module ecmt_step #(
  parameter int COUNT_WIDTH = ecmt_pkg::COUNT_WIDTH_DEF
) (
  input  ecmt_pkg::cfg_t        cfg,
  input  ecmt_pkg::conv_state_t st,
  input  logic [COUNT_WIDTH-1:0] cnt,
  input  ecmt_pkg::in_item_t    item,
  output ecmt_pkg::conv_state_t st_nxt,
  output logic [COUNT_WIDTH-1:0] cnt_nxt,
  output ecmt_pkg::out_item_t   res [ecmt_pkg::MAX_RESULTS],
  output logic [2:0]            res_cnt
);

  always_comb begin
    ecmt_pkg::conv_state_t        s;
    logic                         high;
    logic [1:0]                   add_k;
    logic [1:0]                   nb;
    logic [7:0]                   bb [3];
    logic                         fail_en;
    logic [1:0]                   fail_cause;
    logic [COUNT_WIDTH:0]         sum;
    logic [COUNT_WIDTH-1:0]       c;
    logic [COUNT_WIDTH+ecmt_pkg::CONSUMED_W-1:0] ext;
    logic [2:0]                   n;

    s          = st;
    high       = item.in_byte[7];
    add_k      = 2'd0;
    nb         = 2'd0;
    bb[0]      = item.in_byte;
    bb[1]      = item.in_byte;
    bb[2]      = item.in_byte;
    fail_en    = 1'b0;
    fail_cause = ecmt_pkg::ST_INVALID;

    if (item.byte_present && !st.stopped) begin
      if (cfg.direction == ecmt_pkg::DIR_TO_MULE) begin
        if (st.phase == ecmt_pkg::PH_START) begin
          if (high) begin
            s.held_first = item.in_byte;
            s.phase      = ecmt_pkg::PH_ONE;
          end else if (item.in_byte == 8'd0) begin
            fail_en = 1'b1;
          end else begin
            nb    = 2'd1;
            add_k = 2'd1;
          end
        end else if (high) begin
          // leader, lead byte, trail byte
          nb      = 2'd3;
          bb[0]   = cfg.gb_leader;
          bb[1]   = st.held_first;
          add_k   = 2'd2;
          s.phase = ecmt_pkg::PH_START;
        end else begin
          fail_en = 1'b1;
        end
      end else begin
        if (st.phase == ecmt_pkg::PH_START) begin
          if (high) begin
            if (item.in_byte != cfg.gb_leader) begin
              fail_en    = 1'b1;
              fail_cause = ecmt_pkg::ST_UNTRANS;
            end else begin
              s.held_first = item.in_byte;
              s.phase      = ecmt_pkg::PH_ONE;
            end
          end else if (item.in_byte == 8'd0) begin
            fail_en = 1'b1;
          end else begin
            nb    = 2'd1;
            add_k = 2'd1;
          end
        end else if (!high) begin
          fail_en = 1'b1;
        end else if (st.phase == ecmt_pkg::PH_ONE) begin
          s.held_second = item.in_byte;
          s.phase       = ecmt_pkg::PH_TWO;
        end else begin
          nb      = 2'd2;
          bb[0]   = st.held_second;
          add_k   = 2'd3;
          s.phase = ecmt_pkg::PH_START;
        end
      end
      if (nb == 2'd2) begin
        bb[1] = item.in_byte;
      end
    end

    // saturating add of the bytes just committed
    sum = {1'b0, cnt} + (COUNT_WIDTH+1)'(add_k);
    c   = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];

    // a partial character at the end of the string is truncated
    if (item.end_of_string && !s.stopped && !fail_en && s.phase != ecmt_pkg::PH_START) begin
      fail_en = 1'b1;
    end

    if (fail_en) begin
      s.phase   = ecmt_pkg::PH_START;
      s.stopped = 1'b1;
      if (!cfg.no_error) begin
        s.stop_cause = fail_cause;
      end
    end

    ext = {{ecmt_pkg::CONSUMED_W{1'b0}}, c};

    for (int i = 0; i < ecmt_pkg::MAX_RESULTS; i++) begin
      res[i] = '0;
    end
    n = 3'd0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < nb) begin
        res[i].out_byte = bb[i];
        n = n + 3'd1;
      end
    end
    if (fail_en && !cfg.no_error) begin
      res[n[1:0]].status   = fail_cause;
      res[n[1:0]].consumed = ext[ecmt_pkg::CONSUMED_W-1:0];
      n = n + 3'd1;
    end
    if (item.end_of_string) begin
      res[n[1:0]].is_terminator = 1'b1;
      res[n[1:0]].status        = s.stop_cause;
      res[n[1:0]].consumed      = ext[ecmt_pkg::CONSUMED_W-1:0];
      n = n + 3'd1;
      // rearm for the next string
      s.phase      = ecmt_pkg::PH_START;
      s.stopped    = 1'b0;
      s.stop_cause = ecmt_pkg::ST_OK;
      c            = '0;
    end
    for (int i = 0; i < ecmt_pkg::MAX_RESULTS; i++) begin
      res[i].last_of_run = (3'(i) + 3'd1 == n);
    end

    st_nxt  = s;
    cnt_nxt = c;
    res_cnt = n;
  end

endmodule

// ----- rtl/euc_cn_mule_transcoder.sv -----
// EUC-CN / MULE internal code byte-stream transcoder, top level.
//
// At most one source byte per input item; the direction register picks EUC-CN
// to MULE (ASCII passes, a high byte pair gets the GB2312 leader in front) or
// MULE to EUC-CN (leader checked and stripped). Each item is converted in the
// cycle it is accepted and its zero to four results are written into a
// four-entry group buffer, which drains one result per cycle into the output
// register while the output is not stalled. The next item is taken once the
// group buffer is empty or hands its last result to the output register, so
// single-result items stream at one per cycle when the output is not stalled,
// while the byte that completes a character in EUC-CN to MULE (leader plus
// pair) gives three results, and four if it also ends the string. Output
// stalls hold the drain, and results reach out_valid from the output register.
// Configuration is written through cfg_we/cfg_idx/cfg_wdata and must only
// change while the block is idle. The consumed count saturates at
// 2^COUNT_WIDTH - 1 and is reported on error and terminator results.
`include "euc_cn_mule_transcoder_defines.svh"

module euc_cn_mule_transcoder #(
  parameter int COUNT_WIDTH = ecmt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ecmt_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ecmt_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [ecmt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ecmt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  ecmt_pkg::cfg_t        cfg_r;
  ecmt_pkg::conv_state_t st_r;
  ecmt_pkg::conv_state_t st_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] cnt_nxt;

  ecmt_pkg::out_item_t   res [ecmt_pkg::MAX_RESULTS];
  logic [2:0]            res_cnt;

  // group buffer: results of the last accepted item
  ecmt_pkg::out_item_t   grp_r [ecmt_pkg::MAX_RESULTS];
  logic [2:0]            grp_cnt_r;
  logic [1:0]            grp_idx_r;

  logic                  out_valid_r;
  ecmt_pkg::out_item_t   out_data_r;

  logic                  mv;
  logic                  in_acc;

  // advance one buffered result into the output register when it is free
  assign mv       = (grp_cnt_r != 3'd0) && (!out_valid_r || out_ready);
  // take a new item once the group buffer is empty or giving up its last one;
  // hold off while reset is applied
  assign in_ready = rst_n && ((grp_cnt_r == 3'd0) || (grp_cnt_r == 3'd1 && mv));
  assign in_acc   = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ecmt_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .cfg     (cfg_r),
    .st      (st_r),
    .cnt     (cnt_r),
    .item    (in_data),
    .st_nxt  (st_nxt),
    .cnt_nxt (cnt_nxt),
    .res     (res),
    .res_cnt (res_cnt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction <= 1'b0;
      cfg_r.no_error  <= 1'b0;
      cfg_r.gb_leader <= ecmt_pkg::GB_LEADER_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ecmt_pkg::REG_DIRECTION: cfg_r.direction <= cfg_wdata[0];
        ecmt_pkg::REG_NO_ERROR:  cfg_r.no_error  <= cfg_wdata[0];
        ecmt_pkg::REG_GB_LEADER: cfg_r.gb_leader <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // conversion state: update on every accepted item; held bytes are payload
  // and take no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= ecmt_pkg::PH_START;
      st_r.stopped    <= 1'b0;
      st_r.stop_cause <= ecmt_pkg::ST_OK;
      cnt_r           <= '0;
    end else if (in_acc) begin
      st_r.phase       <= st_nxt.phase;
      st_r.stopped     <= st_nxt.stopped;
      st_r.stop_cause  <= st_nxt.stop_cause;
      st_r.held_first  <= st_nxt.held_first;
      st_r.held_second <= st_nxt.held_second;
      cnt_r            <= cnt_nxt;
    end
  end

  // group buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_cnt_r <= 3'd0;
      grp_idx_r <= 2'd0;
    end else if (in_acc) begin
      grp_cnt_r <= res_cnt;
      grp_idx_r <= 2'd0;
    end else if (mv) begin
      grp_cnt_r <= grp_cnt_r - 3'd1;
      grp_idx_r <= grp_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < ecmt_pkg::MAX_RESULTS; i++) begin
        grp_r[i] <= res[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      out_data_r <= grp_r[grp_idx_r];
    end
  end

  `ECMT_ASSERT_IMP(a_term_is_last, out_valid_r && out_data_r.is_terminator, out_data_r.last_of_run)
  `ECMT_ASSERT_IMP(a_grp_in_range, grp_cnt_r != 3'd0, 3'(grp_idx_r) + grp_cnt_r <= 3'd4)
  `ECMT_ASSERT_NXT(a_end_rearms, in_acc && in_data.end_of_string, !st_r.stopped && cnt_r == '0)
  `ECMT_ASSERT_NXT(a_count_grows, in_acc && !in_data.end_of_string, cnt_r >= $past(cnt_r))

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the EUC-CN / MULE byte-stream transcoder.
`timescale 1ns / 1ps

module tb;

  localparam int  IDLE_MAX    = 10;   // longest sender gap / receiver stall
  localparam int  SETTLE_CYC  = 8;    // quiet cycles after the last result
  localparam int  PHASE_ITEMS = 27;   // random items per register setting
  localparam logic [31:0] COUNT_SAT = 32'h7FFF_FFFF;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  ecmt_pkg::in_item_t   in_data;
  logic                 out_valid;
  logic                 out_ready;
  ecmt_pkg::out_item_t  out_data;
  logic                 cfg_we;
  logic [ecmt_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ecmt_pkg::CFG_DATA_W-1:0] cfg_wdata;

  euc_cn_mule_transcoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Transcoder shadow: register copy plus character state.
  logic              dir_sh;
  logic              quiet_sh;
  logic [7:0]        leader_sh;
  ecmt_pkg::phase_t  char_ph;
  logic [7:0]        lead_byte;
  logic [7:0]        second_byte;
  logic [31:0]       committed;
  logic              halted;
  logic [1:0]        halt_cause;

  ecmt_pkg::out_item_t item_results[$];     // results of the item being predicted
  ecmt_pkg::out_item_t pending_results[$];  // expected results still on their way

  logic        idle_on;
  int          stall_left;
  int          items_sent;
  int          results_seen;
  int          mismatches;

  // ---------------------------------------------------------------------------
  // Transcoder prediction
  // ---------------------------------------------------------------------------
  function automatic void emit(input logic [7:0] b, input logic term,
                               input logic [1:0] st, input logic [31:0] cnt);
    ecmt_pkg::out_item_t r;
    r.out_byte      = b;
    r.is_terminator = term;
    r.status        = st;
    r.consumed      = cnt[ecmt_pkg::CONSUMED_W-1:0];
    r.last_of_run   = 1'b0;
    item_results.push_back(r);
  endfunction

  function automatic void commit_bytes(input int k);
    if (committed + k > COUNT_SAT) committed = COUNT_SAT;
    else committed = committed + k;
  endfunction

  // Drop the rest of the string; report the cause unless running quiet.
  function automatic void abort_string(input logic [1:0] why);
    char_ph = ecmt_pkg::PH_START;
    halted  = 1'b1;
    if (!quiet_sh) begin
      halt_cause = why;
      emit(8'h00, 1'b0, why, committed);
    end
  endfunction

  function automatic void encode_to_mule(input logic [7:0] b);
    if (char_ph == ecmt_pkg::PH_START) begin
      if (b[7]) begin
        lead_byte = b;
        char_ph   = ecmt_pkg::PH_ONE;
      end else if (b == 8'h00) begin
        abort_string(ecmt_pkg::ST_INVALID);
      end else begin
        emit(b, 1'b0, ecmt_pkg::ST_OK, 32'd0);
        commit_bytes(1);
      end
    end else if (b[7]) begin
      // any held phase acts as one held lead byte in this direction
      emit(leader_sh, 1'b0, ecmt_pkg::ST_OK, 32'd0);
      emit(lead_byte, 1'b0, ecmt_pkg::ST_OK, 32'd0);
      emit(b, 1'b0, ecmt_pkg::ST_OK, 32'd0);
      commit_bytes(2);
      char_ph = ecmt_pkg::PH_START;
    end else begin
      abort_string(ecmt_pkg::ST_INVALID);
    end
  endfunction

  function automatic void decode_to_euc(input logic [7:0] b);
    if (char_ph == ecmt_pkg::PH_START) begin
      if (b[7]) begin
        if (b != leader_sh) begin
          abort_string(ecmt_pkg::ST_UNTRANS);
        end else begin
          lead_byte = b;
          char_ph   = ecmt_pkg::PH_ONE;
        end
      end else if (b == 8'h00) begin
        abort_string(ecmt_pkg::ST_INVALID);
      end else begin
        emit(b, 1'b0, ecmt_pkg::ST_OK, 32'd0);
        commit_bytes(1);
      end
    end else if (!b[7]) begin
      abort_string(ecmt_pkg::ST_INVALID);
    end else if (char_ph == ecmt_pkg::PH_ONE) begin
      second_byte = b;
      char_ph     = ecmt_pkg::PH_TWO;
    end else begin
      emit(second_byte, 1'b0, ecmt_pkg::ST_OK, 32'd0);
      emit(b, 1'b0, ecmt_pkg::ST_OK, 32'd0);
      commit_bytes(3);
      char_ph = ecmt_pkg::PH_START;
    end
  endfunction

  // Work out the results of one accepted item and queue them.
  function automatic void transcode_item(input ecmt_pkg::in_item_t it);
    item_results.delete();
    if (it.byte_present && !halted) begin
      if (dir_sh == ecmt_pkg::DIR_TO_MULE) encode_to_mule(it.in_byte);
      else decode_to_euc(it.in_byte);
    end
    if (it.end_of_string) begin
      if (!halted && char_ph != ecmt_pkg::PH_START) abort_string(ecmt_pkg::ST_INVALID);
      emit(8'h00, 1'b1, halt_cause, committed);
      char_ph    = ecmt_pkg::PH_START;
      committed  = 32'd0;
      halted     = 1'b0;
      halt_cause = ecmt_pkg::ST_OK;
    end
    if (item_results.size() > 0)
      item_results[item_results.size()-1].last_of_run = 1'b1;
    foreach (item_results[i]) pending_results.push_back(item_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ecmt_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result byte=%02h term=%0b st=%0d cnt=%0d last=%0b",
                   $time, out_data.out_byte, out_data.is_terminator, out_data.status,
                   out_data.consumed, out_data.last_of_run);
      end else begin
        e = pending_results.pop_front();
        if (out_data.out_byte !== e.out_byte || out_data.is_terminator !== e.is_terminator ||
            out_data.status !== e.status || out_data.consumed !== e.consumed ||
            out_data.last_of_run !== e.last_of_run) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected byte=%02h term=%0b st=%0d cnt=%0d last=%0b", $time,
                     e.out_byte, e.is_terminator, e.status, e.consumed, e.last_of_run);
            $display("%0t: actual   byte=%02h term=%0b st=%0d cnt=%0d last=%0b", $time,
                     out_data.out_byte, out_data.is_terminator, out_data.status,
                     out_data.consumed, out_data.last_of_run);
          end
        end
      end
      // draw the stall ahead of the next result
      stall_left = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    end
  end

  // Hold ready low while a stall is running, otherwise keep it high.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one item, after a random gap if idling is on, and hold it until the block takes it.
  task automatic send_item(input logic [7:0] b, input logic present, input logic eos);
    int gap;
    gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = '{in_byte: b, byte_present: present, end_of_string: eos};
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    transcode_item(in_data);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Write one register; the block must be idle.
  task automatic set_reg(input logic [ecmt_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    if (idx == ecmt_pkg::REG_DIRECTION) dir_sh = val[0];
    else if (idx == ecmt_pkg::REG_NO_ERROR) quiet_sh = val[0];
    else if (idx == ecmt_pkg::REG_GB_LEADER) leader_sh = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input logic dir, input logic quiet, input logic [7:0] leader);
    settle();
    set_reg(ecmt_pkg::REG_DIRECTION, {7'd0, dir});
    set_reg(ecmt_pkg::REG_NO_ERROR, {7'd0, quiet});
    set_reg(ecmt_pkg::REG_GB_LEADER, leader);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  // Reset settings: ASCII passthrough, pairs at both byte extremes, end marker.
  task automatic test_reset_defaults();
    send_item(8'h41, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);   // empty item, nothing comes back
    send_item(8'hA5, 1'b0, 1'b1);   // end-only marker
  endtask

  // Zero byte, low byte after a lead, truncation, and a pair closing the string.
  task automatic test_to_mule_errors();
    send_item(8'h41, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h42, 1'b1, 1'b1);   // ignored byte, then the terminator
    send_item(8'hC1, 1'b1, 1'b0);
    send_item(8'h41, 1'b1, 1'b1);
    send_item(8'hB0, 1'b1, 1'b1);   // cut off by the end of the string
    send_item(8'hB0, 1'b1, 1'b0);
    send_item(8'hC1, 1'b1, 1'b1);   // three bytes plus terminator
  endtask

  // Leader stripped, wrong leader, low byte inside a character.
  task automatic test_to_euc();
    configure(1'b1, 1'b0, ecmt_pkg::GB_LEADER_RST);
    send_item(8'h81, 1'b1, 1'b0);
    send_item(8'hB0, 1'b1, 1'b0);
    send_item(8'hA1, 1'b1, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h82, 1'b1, 1'b1);   // untranslatable
    send_item(8'h81, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b1);
  endtask

  // Quiet mode: errors stop the string without an error result.
  task automatic test_quiet_stop();
    configure(1'b1, 1'b1, ecmt_pkg::GB_LEADER_RST);
    send_item(8'h31, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h32, 1'b1, 1'b1);
    send_item(8'h81, 1'b1, 1'b1);   // truncated, quiet
  endtask

  // Leader register at its extremes, including one below the high-bit range.
  task automatic test_leader_extremes();
    configure(1'b0, 1'b0, 8'hFF);
    send_item(8'hA1, 1'b1, 1'b0);
    send_item(8'hA2, 1'b1, 1'b1);
    configure(1'b0, 1'b0, 8'h7F);
    send_item(8'hD0, 1'b1, 1'b0);
    send_item(8'hD1, 1'b1, 1'b1);
    configure(1'b1, 1'b0, 8'h7F);
    send_item(8'h80, 1'b1, 1'b1);   // no high byte can match
    configure(1'b1, 1'b0, 8'h80);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
  endtask

  // Flip the direction while a character is half done.
  task automatic test_direction_switch();
    configure(1'b0, 1'b0, ecmt_pkg::GB_LEADER_RST);
    send_item(8'hB0, 1'b1, 1'b0);
    settle();
    set_reg(ecmt_pkg::REG_DIRECTION, 8'd1);
    send_item(8'hA1, 1'b1, 1'b0);
    send_item(8'hA2, 1'b1, 1'b1);
    send_item(8'h81, 1'b1, 1'b0);
    send_item(8'hB0, 1'b1, 1'b0);
    settle();
    set_reg(ecmt_pkg::REG_DIRECTION, 8'd0);
    send_item(8'hC0, 1'b1, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Random strings
  // ---------------------------------------------------------------------------
  // Mostly well-formed characters, with stray bytes, zeros and truncation.
  task automatic send_string(input int nchar);
    logic [7:0] s[$];
    int         k;
    int         pick;
    logic       split_end;
    for (k = 0; k < nchar; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        s.push_back(8'h00);
      end else if (pick < 9) begin
        s.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 40) begin
        s.push_back(8'($urandom_range(1, 127)));
      end else begin
        if (dir_sh != ecmt_pkg::DIR_TO_MULE) s.push_back(leader_sh);
        s.push_back(8'($urandom_range(128, 255)));
        s.push_back(8'($urandom_range(128, 255)));
      end
    end
    if ($urandom_range(0, 6) == 0) begin
      if (dir_sh == ecmt_pkg::DIR_TO_MULE) begin
        s.push_back(8'($urandom_range(128, 255)));
      end else begin
        s.push_back(leader_sh);
        if ($urandom_range(0, 1) == 1) s.push_back(8'($urandom_range(128, 255)));
      end
    end
    split_end = (s.size() == 0) || ($urandom_range(0, 3) == 0);
    for (k = 0; k < s.size(); k++) begin
      if ($urandom_range(0, 24) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(s[k], 1'b1, !split_end && (k == s.size() - 1));
    end
    if (split_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic test_random_strings();
    int   p;
    int   start;
    logic [7:0] leader;
    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: leader = 8'h80;
        1: leader = 8'hFF;
        2: leader = ecmt_pkg::GB_LEADER_RST;
        default: leader = 8'($urandom_range(128, 255));
      endcase
      configure(p[0], p[2], leader);
      // every third setting runs back to back with no idling on either side
      idle_on = (p % 3 != 2);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        send_string($urandom_range(0, 8));
        if ($urandom_range(0, 9) == 0) settle();
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    idle_on    = 1'b1;
    stall_left = 0;
    items_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    // shadow starts from the reset values of the block
    dir_sh      = ecmt_pkg::DIR_TO_MULE;
    quiet_sh    = 1'b0;
    leader_sh   = ecmt_pkg::GB_LEADER_RST;
    char_ph     = ecmt_pkg::PH_START;
    lead_byte   = 8'h00;
    second_byte = 8'h00;
    committed   = 32'd0;
    halted      = 1'b0;
    halt_cause  = ecmt_pkg::ST_OK;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_to_mule_errors();
    test_to_euc();
    test_quiet_stop();
    test_leader_extremes();
    test_direction_switch();
    test_random_strings();
    settle();

    $display("Sent %0d items and checked %0d results over both directions,", items_sent,
             results_seen);
    $display("quiet and reporting error modes, and leader values 0x7f to 0xff.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
